@@ hw/rtl/bbd_pkg.sv @@
// ----------------------------------------------------------------------------
// bbd_pkg
// shared types, constants and the site colour function of the bilinear bayer demosaic
// ----------------------------------------------------------------------------
package bbd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 12;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BAYER_ORDER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    // colour codes
    localparam logic [1:0] COL_RED   = 2'd0;
    localparam logic [1:0] COL_GREEN = 2'd1;
    localparam logic [1:0] COL_BLUE  = 2'd2;

    // one classified pixel job between front and back
    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
        logic [POS_W-1:0]    row;
        logic [POS_W-1:0]    col;
        logic [POS_W-1:0]    brow;
        logic [POS_W-1:0]    bcol;
        logic                rowcopy;
        logic                colcopy;
    } t_job;

    // colour of a site: order, row parity, column parity
    function automatic logic [1:0] site_colour(input logic [1:0] order,
                                               input logic rp, input logic cp);
        logic [1:0] k;
        k = {rp, cp};
        unique case (order)
            2'd0: site_colour = (k == 2'd0) ? COL_RED  : (k == 2'd3) ? COL_BLUE  : COL_GREEN;
            2'd1: site_colour = (k == 2'd0) ? COL_BLUE : (k == 2'd3) ? COL_RED   : COL_GREEN;
            2'd2: site_colour = (k == 2'd1) ? COL_RED  : (k == 2'd2) ? COL_BLUE  : COL_GREEN;
            default: site_colour = (k == 2'd1) ? COL_BLUE : (k == 2'd2) ? COL_RED : COL_GREEN;
        endcase
    endfunction

endpackage

@@ hw/rtl/bilinear_bayer_demosaic.sv @@
// an accepted sample's interior pixel passes the stage 1, 2 and 3 registers, the job queue and the output register
// throughput: one sample per cycle; border jobs expand to up to 4 items, one per cycle while the output is ready,
// from an 8-entry job queue; input stalls when the queue cannot hold in-flight jobs
// reset: synchronous active low; position, queue and valid flags clear, registers take
// their defaults (rggb, 1920 x 1080); line stores are not cleared
// ----------------------------------------------------------------------------
// bilinear_bayer_demosaic
// streaming bilinear demosaic of raw bayer samples to rgb pixels
// ----------------------------------------------------------------------------
module bilinear_bayer_demosaic
    import bbd_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // raw_sample
    input  logic        s_axis_tuser,   // frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // red_value, green_value, blue_value, pixel_row, pixel_col
    output logic        m_axis_tlast,   // last_of_run
    input  logic        i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    localparam int QDEPTH = 8;
    localparam int QCW = $clog2(QDEPTH+1);

    logic [1:0]       r_order;
    logic [CFG_W-1:0] r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 2'd0;
            r_width <= CFG_W'(1920);
            r_height <= CFG_W'(1080);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BAYER_ORDER:  r_order <= i_cfg_data[1:0];
                CFG_IMAGE_WIDTH:  r_width <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic job_valid, q_valid, q_pop;
    t_job job, q_job;
    logic [QCW-1:0] q_count;
    logic [SAMPLE_W-1:0] red, green, blue;
    logic [POS_W-1:0] prow, pcol;

    // up to 3 jobs in flight in the front stages plus one arriving
    assign s_axis_tready = (q_count <= QCW'(QDEPTH - 4));

    bbd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .i_sample(s_axis_tdata),
        .i_frame_start(s_axis_tuser), .i_advance(s_axis_tready),
        .i_order(r_order), .i_width(r_width), .i_height(r_height),
        .o_job_valid(job_valid), .o_job(job)
    );

    bbd_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk, .i_rst_n, .i_push(job_valid), .i_job(job),
        .i_pop(q_pop), .o_valid(q_valid), .o_job(q_job), .o_count(q_count)
    );

    bbd_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(q_valid), .i_job(q_job), .o_job_pop(q_pop),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_red(red), .o_green(green), .o_blue(blue),
        .o_row(prow), .o_col(pcol), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {pcol, prow, blue, green, red};

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= QCW'(QDEPTH)) else $error("job queue overflow");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid) else $error("pop of empty job queue");
    a_last_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (m_axis_tvalid && m_axis_tlast)) else $error("last missing");
endmodule

@@ hw/rtl/bbd_front.sv @@
// ----------------------------------------------------------------------------
// bbd_front
// line stores, 3x3 window and interpolation; emits one job per interior pixel
// ----------------------------------------------------------------------------
module bbd_front
    import bbd_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_frame_start,
    input  logic                i_advance,
    input  logic [1:0]          i_order,
    input  logic [CFG_W-1:0]    i_width,
    input  logic [CFG_W-1:0]    i_height,
    output logic                o_job_valid,
    output t_job                o_job
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int SW = (CW > RW ? CW : RW) + 1;

    logic [SAMPLE_W-1:0] r_mem_mid [MAX_WIDTH];
    logic [SAMPLE_W-1:0] r_mem_top [MAX_WIDTH];

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic [CW-1:0] c;
    logic [RW-1:0] r;
    logic          fire;

    // size saturation, rounded down to an even size
    always_comb begin
        logic [SW-1:0] wv, hv;
        wv = SW'(i_width);
        hv = SW'(i_height);
        if (wv < SW'(4)) wv = SW'(4);
        if (wv > SW'(MAX_WIDTH)) wv = SW'(MAX_WIDTH);
        if (hv < SW'(4)) hv = SW'(4);
        if (hv > SW'(MAX_HEIGHT)) hv = SW'(MAX_HEIGHT);
        w_eff = CW'({wv[SW-1:1], 1'b0});
        h_eff = RW'({hv[SW-1:1], 1'b0});
    end

    assign fire = i_valid && i_advance;

    always_comb begin
        if (i_frame_start || r_col >= w_eff || r_row >= h_eff) begin
            c = '0;
            r = '0;
        end else begin
            c = r_col;
            r = r_row;
        end
    end

    // stage 1: line store write and read, sample and position registered
    logic                r_s1_valid;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic [SAMPLE_W-1:0] r_s1_top, r_s1_mid;
    logic [CW-1:0]       r_s1_c;
    logic [RW-1:0]       r_s1_r;
    logic [AW-1:0]       addr;
    assign addr = c[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_mem_mid[addr] <= i_sample;
            r_mem_top[addr] <= r_mem_mid[addr];
            r_s1_top <= r_mem_top[addr];
            r_s1_mid <= r_mem_mid[addr];
            r_s1_sample <= i_sample;
            r_s1_c <= c;
            r_s1_r <= r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= fire;
            if (fire) begin
                if (c + CW'(1) >= w_eff) begin
                    r_col <= '0;
                    r_row <= (r + RW'(1) >= h_eff) ? '0 : r + RW'(1);
                end else begin
                    r_col <= c + CW'(1);
                    r_row <= r;
                end
            end
        end
    end

    // stage 2: window shift
    logic [SAMPLE_W-1:0] r_win [9];
    logic                r_s2_valid;
    logic [CW-1:0]       r_s2_c;
    logic [RW-1:0]       r_s2_r;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            for (int y = 0; y < 3; y++) begin
                r_win[y*3]   <= r_win[y*3+1];
                r_win[y*3+1] <= r_win[y*3+2];
            end
            r_win[2] <= r_s1_top;
            r_win[5] <= r_s1_mid;
            r_win[8] <= r_s1_sample;
            r_s2_c <= r_s1_c;
            r_s2_r <= r_s1_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s2_valid <= 1'b0;
        else          r_s2_valid <= r_s1_valid;
    end

    // stage 3: interpolation
    logic [SAMPLE_W+1:0] orth, diag;
    logic [SAMPLE_W:0]   horiz, vert;
    logic [CW-1:0]       cc;
    logic [RW-1:0]       cr;
    logic [1:0]          site, nsite;
    t_job                job;

    always_comb begin
        orth  = (SAMPLE_W+2)'(r_win[1]) + (SAMPLE_W+2)'(r_win[3])
              + (SAMPLE_W+2)'(r_win[5]) + (SAMPLE_W+2)'(r_win[7]);
        diag  = (SAMPLE_W+2)'(r_win[0]) + (SAMPLE_W+2)'(r_win[2])
              + (SAMPLE_W+2)'(r_win[6]) + (SAMPLE_W+2)'(r_win[8]);
        horiz = (SAMPLE_W+1)'(r_win[3]) + (SAMPLE_W+1)'(r_win[5]);
        vert  = (SAMPLE_W+1)'(r_win[1]) + (SAMPLE_W+1)'(r_win[7]);
        cc = r_s2_c - CW'(1);
        cr = r_s2_r - RW'(1);
        site  = site_colour(i_order, cr[0], cc[0]);
        nsite = site_colour(i_order, cr[0], ~cc[0]);
        job = '0;
        unique case (site)
            COL_RED: begin
                job.red = r_win[4]; job.green = orth[SAMPLE_W+1:2];
                job.blue = diag[SAMPLE_W+1:2];
            end
            COL_BLUE: begin
                job.red = diag[SAMPLE_W+1:2]; job.green = orth[SAMPLE_W+1:2];
                job.blue = r_win[4];
            end
            default: begin
                job.green = r_win[4];
                if (nsite == COL_RED) begin
                    job.red = horiz[SAMPLE_W:1]; job.blue = vert[SAMPLE_W:1];
                end else begin
                    job.red = vert[SAMPLE_W:1]; job.blue = horiz[SAMPLE_W:1];
                end
            end
        endcase
        job.row = POS_W'(cr);
        job.col = POS_W'(cc);
        job.rowcopy = (cr == RW'(1)) || (cr == h_eff - RW'(2));
        job.colcopy = (cc == CW'(1)) || (cc == w_eff - CW'(2));
        job.brow = (cr == RW'(1)) ? '0 : POS_W'(h_eff - RW'(1));
        job.bcol = (cc == CW'(1)) ? '0 : POS_W'(w_eff - CW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) o_job <= job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_job_valid <= 1'b0;
        else o_job_valid <= r_s2_valid && r_s2_r >= RW'(2) && r_s2_c >= CW'(2);
    end

endmodule

@@ hw/rtl/bbd_queue.sv @@
// ----------------------------------------------------------------------------
// bbd_queue
// small job fifo between front and back
// ----------------------------------------------------------------------------
module bbd_queue
    import bbd_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW = $clog2(DEPTH);
    t_job r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [$clog2(DEPTH+1)-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + PW'(1);
            if (i_pop)  r_rp <= (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + PW'(1);
            r_cnt <= r_cnt + (i_push ? 1'b1 : 1'b0) - (i_pop ? 1'b1 : 1'b0);
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign o_count = r_cnt;
endmodule

@@ hw/rtl/bbd_back.sv @@
// ----------------------------------------------------------------------------
// bbd_back
// expands one job into the pixel and its border copies
// ----------------------------------------------------------------------------
module bbd_back
    import bbd_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  t_job           i_job,
    output logic           o_job_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [SAMPLE_W-1:0] o_red,
    output logic [SAMPLE_W-1:0] o_green,
    output logic [SAMPLE_W-1:0] o_blue,
    output logic [POS_W-1:0] o_row,
    output logic [POS_W-1:0] o_col,
    output logic           o_last
);
    logic [1:0] r_k;
    logic [1:0] nres;
    logic       take, last;
    logic       use_br, use_bc;

    assign nres = i_job.rowcopy && i_job.colcopy ? 2'd3 :
                  (i_job.rowcopy || i_job.colcopy) ? 2'd1 : 2'd0;
    assign last = (r_k == nres);
    assign take = i_job_valid && (!o_valid || i_ready);
    assign o_job_pop = take && last;

    // result k: 0 interior, then row copy, column copy, corner
    always_comb begin
        use_br = 1'b0; use_bc = 1'b0;
        unique case (r_k)
            2'd0: ;
            2'd1: begin use_br = i_job.rowcopy; use_bc = !i_job.rowcopy; end
            2'd2: use_bc = 1'b1;
            default: begin use_br = 1'b1; use_bc = 1'b1; end
        endcase
        if (r_k == 2'd2 && !i_job.rowcopy) use_bc = 1'b1;
        if (r_k == 2'd2) use_br = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            o_red   <= i_job.red;
            o_green <= i_job.green;
            o_blue  <= i_job.blue;
            o_row   <= use_br ? i_job.brow : i_job.row;
            o_col   <= use_bc ? i_job.bcol : i_job.col;
            o_last  <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_k <= '0;
        end else begin
            if (take) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
            if (take) r_k <= last ? 2'd0 : r_k + 2'd1;
        end
    end
endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bilinear bayer demosaic: samples stream in with
// random gaps and output stalls, every output item is checked field by field
// against a behavioral predictor; phases cover all bayer orders, small frame
// sizes, saturated sizes, a mid-frame size change and a long output stall
// ----------------------------------------------------------------------------
module tb_top;
    import bbd_pkg::*;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [11:0] row;
        logic [11:0] col;
        logic        last;
    } t_pixel;

    typedef struct {
        logic [15:0] sample;
        logic        fs;
        logic        chk;
        logic [15:0] rgb;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // raw_sample
    logic        s_axis_tuser;   // frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // red, green, blue, pixel_row, pixel_col
    logic        m_axis_tlast;   // last_of_run
    logic        i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    bilinear_bayer_demosaic dut (.*);

    // predictor state
    logic [15:0] row_prev [4096];
    logic [15:0] row_prev2 [4096];
    logic [15:0] win [9];
    int unsigned pos_r, pos_c;
    logic [1:0]  cur_order;
    logic [12:0] cur_w, cur_h;

    t_pixel pixel_q[$];
    int     errors;
    int     idle_pct, stall_pct;
    int     hold_req;
    t_dir_row dir_tab[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    function automatic int unsigned fit_dim(int unsigned v);
        if (v < 4) v = 4;
        if (v > 4096) v = 4096;
        return v & ~32'd1;
    endfunction

    function automatic logic [1:0] colour_of(int unsigned r, int unsigned c);
        logic [1:0] k;
        k = {r[0], c[0]};
        case (cur_order)
            2'd0: return (k == 2'd0) ? COL_RED : (k == 2'd3) ? COL_BLUE : COL_GREEN;
            2'd1: return (k == 2'd0) ? COL_BLUE : (k == 2'd3) ? COL_RED : COL_GREEN;
            2'd2: return (k == 2'd1) ? COL_RED : (k == 2'd2) ? COL_BLUE : COL_GREEN;
            default: return (k == 2'd1) ? COL_BLUE : (k == 2'd2) ? COL_RED : COL_GREEN;
        endcase
    endfunction

    task automatic demosaic_predict(input logic [15:0] s, input logic fs, output int n);
        int unsigned w, h, r, c, cr, cc, orth, diag, horiz, vert, br, bc;
        logic [15:0] top, mid;
        logic rowcopy, colcopy;
        t_pixel px;
        w = fit_dim(cur_w);
        h = fit_dim(cur_h);
        n = 0;
        if (fs || pos_c >= w || pos_r >= h) begin
            pos_r = 0;
            pos_c = 0;
        end
        r = pos_r;
        c = pos_c;
        top = row_prev2[c];
        mid = row_prev[c];
        row_prev2[c] = mid;
        row_prev[c] = s;
        for (int y = 0; y < 3; y++) begin
            win[y*3] = win[y*3+1];
            win[y*3+1] = win[y*3+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = s;
        if (r >= 2 && c >= 2) begin
            cr = r - 1;
            cc = c - 1;
            orth = (win[1] + win[3] + win[5] + win[7]) >> 2;
            diag = (win[0] + win[2] + win[6] + win[8]) >> 2;
            horiz = (win[3] + win[5]) >> 1;
            vert = (win[1] + win[7]) >> 1;
            rowcopy = (cr == 1 || cr == h - 2);
            colcopy = (cc == 1 || cc == w - 2);
            br = (cr == 1) ? 0 : h - 1;
            bc = (cc == 1) ? 0 : w - 1;
            px.last = 1'b0;
            case (colour_of(cr, cc))
                COL_RED: begin
                    px.red = win[4]; px.green = orth[15:0]; px.blue = diag[15:0];
                end
                COL_BLUE: begin
                    px.red = diag[15:0]; px.green = orth[15:0]; px.blue = win[4];
                end
                default: begin
                    px.green = win[4];
                    // red on the same row as this green site
                    if (colour_of(cr, cc + 1) == COL_RED) begin
                        px.red = horiz[15:0]; px.blue = vert[15:0];
                    end else begin
                        px.red = vert[15:0]; px.blue = horiz[15:0];
                    end
                end
            endcase
            px.row = cr[11:0]; px.col = cc[11:0];
            pixel_q.push_back(px); n++;
            if (rowcopy) begin
                px.row = br[11:0]; px.col = cc[11:0];
                pixel_q.push_back(px); n++;
            end
            if (colcopy) begin
                px.row = cr[11:0]; px.col = bc[11:0];
                pixel_q.push_back(px); n++;
            end
            if (rowcopy && colcopy) begin
                px.row = br[11:0]; px.col = bc[11:0];
                pixel_q.push_back(px); n++;
            end
            pixel_q[pixel_q.size()-1].last = 1'b1;
        end
        pos_c = c + 1;
        if (pos_c >= w) begin
            pos_c = 0;
            pos_r = r + 1;
            if (pos_r >= h) pos_r = 0;
        end
    endtask

    task automatic send_sample(input logic [15:0] s, input logic fs, output int n);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= s;
        s_axis_tuser <= fs;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        demosaic_predict(s, fs, n);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [12:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == CFG_BAYER_ORDER) cur_order = val[1:0];
        else if (idx == CFG_IMAGE_WIDTH) cur_w = val;
        else if (idx == CFG_IMAGE_HEIGHT) cur_h = val;
    endtask

    task automatic set_frame(input logic [1:0] ord, input logic [12:0] w, input logic [12:0] h);
        cfg_write(CFG_BAYER_ORDER, {11'd0, ord});
        cfg_write(CFG_IMAGE_WIDTH, w);
        cfg_write(CFG_IMAGE_HEIGHT, h);
        i_cfg_we <= 1'b0;
    endtask

    // idle the input, drain expectations, then let the pipeline settle
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic send_frames(input int count, input int noise_pct);
        int n, total;
        logic fs;
        total = fit_dim(cur_w) * fit_dim(cur_h) * count;
        for (int k = 0; k < total; k++) begin
            // occasional stray frame_start restarts the frame
            fs = (k == 0) || ($urandom_range(99) < noise_pct);
            send_sample($urandom_range(16'hffff), fs, n);
        end
    endtask

    // receiver: stalls at random, or holds off for a requested stretch
    initial begin
        t_pixel got, want;
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                       m_axis_tdata[59:48], m_axis_tdata[71:60], m_axis_tlast};
                if (pixel_q.size() == 0) begin
                    $display("%t unexpected item %h", $realtime, got);
                    errors++;
                end else begin
                    want = pixel_q.pop_front();
                    if (got !== want) begin
                        $display("%t mismatch rgb/row/col/last expected %h %h %h %0d %0d %b",
                                 $realtime, want.red, want.green, want.blue, want.row,
                                 want.col, want.last);
                        $display("%t                          actual   %h %h %h %0d %0d %b",
                                 $realtime, got.red, got.green, got.blue, got.row,
                                 got.col, got.last);
                        errors++;
                    end
                end
            end
            if (hold_req != 0) begin
                hold = hold_req;
                hold_req = 0;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        int n, mode;
        logic [12:0] wl [6];
        logic [12:0] hl [6];
        wl = '{13'd6, 13'd8, 13'd5, 13'd0, 13'd10, 13'd4};
        hl = '{13'd4, 13'd6, 13'd1, 13'd8, 13'd3, 13'd5};
        errors = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 0;
        pos_r = 0; pos_c = 0;
        cur_order = 2'd0; cur_w = 13'd1920; cur_h = 13'd1080;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_BAYER_ORDER;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: flat full-scale 4x4 frame, then a checkerboard start
        set_frame(2'd0, 13'd4, 13'd4);
        for (int k = 0; k < 16; k++)
            dir_tab.push_back('{16'hffff, k == 0, 1'b1, 16'hffff});
        for (int k = 0; k < 8; k++)
            dir_tab.push_back('{(k[0] ^ k[2]) ? 16'hffff : 16'h0000, k == 0, 1'b0, 16'h0});
        foreach (dir_tab[i]) begin
            send_sample(dir_tab[i].sample, dir_tab[i].fs, n);
            if (dir_tab[i].chk)
                for (int j = pixel_q.size() - n; j < pixel_q.size(); j++)
                    if (pixel_q[j].red !== dir_tab[i].rgb || pixel_q[j].green !== dir_tab[i].rgb
                        || pixel_q[j].blue !== dir_tab[i].rgb) begin
                        $display("%t flat frame expected %h actual %h %h %h", $realtime,
                                 dir_tab[i].rgb, pixel_q[j].red, pixel_q[j].green,
                                 pixel_q[j].blue);
                        errors++;
                    end
        end
        drain();

        // random phases over all orders, sizes and idle modes
        for (int p = 0; p < 12; p++) begin
            mode = p % 4;
            idle_pct = (mode == 1) ? 67 : (mode == 3) ? 37 : 0;
            stall_pct = (mode == 2) ? 67 : (mode == 3) ? 37 : 0;
            set_frame(p[1:0], wl[p % 6], hl[(p + 1) % 6]);
            if (p == 4) hold_req = 300;
            send_frames(1, 3);
            drain();
        end

        // size change mid-frame leaves the position outside the frame
        idle_pct = 0; stall_pct = 0;
        set_frame(2'd2, 13'd10, 13'd6);
        for (int k = 0; k < 26; k++) send_sample($urandom_range(16'hffff), k == 0, n);
        drain();
        set_frame(2'd2, 13'd4, 13'd6);
        for (int k = 0; k < 24; k++) send_sample($urandom_range(16'hffff), 1'b0, n);
        drain();

        // saturated heights: first rows of the tallest frame
        set_frame(2'd1, 13'd4, 13'h1fff);
        for (int k = 0; k < 16; k++) send_sample($urandom_range(16'hffff), k == 0, n);
        drain();
        set_frame(2'd3, 13'd6, 13'd4096);
        for (int k = 0; k < 18; k++) send_sample($urandom_range(16'hffff), k == 0, n);
        drain();

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
